/* hdl/bgq_pkg.sv */
// Shared types and constants of the beat grid quantizer.
// Used by bgq_ctrl, bgq_datapath and beat_grid_quantizer_top; no dependencies.
package bgq_pkg;

  localparam int BGQ_MAX_BEAT_COUNT = 2048;
  localparam int BGQ_MAX_SUBDIV     = 4;

  localparam int SPB_W   = 20;
  localparam int SUBD_W  = 3;
  localparam int POS_W   = 24;
  localparam int STR_W   = 9;
  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 11;
  localparam int CFG_A_W = 3;
  localparam int CFG_D_W = 24;
  localparam int DIVC_W  = $clog2(SPB_W + 1);

  localparam logic [SPB_W-1:0]  SPB_RST    = SPB_W'(22050);
  localparam logic [SUBD_W-1:0] SUBD_RST   = SUBD_W'(4);
  localparam logic [POS_W-1:0]  GLEN_RST   = '0;
  localparam logic [STR_W-1:0]  STR_RST    = STR_W'(205);
  localparam logic [POS_W-1:0]  SLIM_RST   = POS_W'(44100);
  localparam logic [STR_W-1:0]  STR_FULL   = STR_W'(256);
  localparam logic [POS_W-1:0]  POS_MAX    = '1;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_SPB  = 3'd0,
    CFG_SUBD = 3'd1,
    CFG_GLEN = 3'd2,
    CFG_STR  = 3'd3,
    CFG_SLIM = 3'd4
  } cfg_reg_t;

  typedef enum logic [FUNC_W-1:0] {
    FN_QUANT  = 2'd0,
    FN_ONBEAT = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_MUL,
    ST_RES
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic scan_step;
    logic mul;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic scan_done;
  } status_t;

endpackage

/* hdl/bgq_ctrl.sv */
// Sequencing state machine of the beat grid quantizer.
// Depends on bgq_pkg; drives commands into bgq_datapath.
module bgq_ctrl
  import bgq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t sts,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_stall      = 1'b1;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = ST_SCAN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        // hold the result until the output slot is free
        if (!out_valid_r || !out_stall) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* hdl/bgq_datapath.sv */
// Datapath of the beat grid quantizer: configuration registers, step divider,
// grid walker, snap multiplier and result register. Depends on bgq_pkg.
module bgq_datapath
  import bgq_pkg::*;
#(
  parameter int MAX_BEAT_COUNT   = BGQ_MAX_BEAT_COUNT,
  parameter int MAX_SUBDIVISIONS = BGQ_MAX_SUBDIV
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output status_t            sts,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [POS_W-1:0]   in_sample_pos,
  input  logic [POS_W-1:0]   in_tolerance,
  output logic [POS_W-1:0]   out_quantized_pos,
  output logic               out_on_beat,
  output logic               out_beat_found,
  output logic [IDX_W-1:0]   out_beat_index
);

  localparam int BCNT_W = $clog2(MAX_BEAT_COUNT + 1);
  localparam int TOTAL  = MAX_BEAT_COUNT * MAX_SUBDIVISIONS;
  localparam int LST_W  = $clog2(TOTAL + 8);
  localparam int BP_W   = POS_W + 1;
  localparam int PP_W   = POS_W + 2;
  localparam int PROD_W = POS_W + STR_W;

  // configuration
  logic [SPB_W-1:0]  spb_r;
  logic [SUBD_W-1:0] subd_r;
  logic [POS_W-1:0]  glen_r;
  logic [STR_W-1:0]  str_r;
  logic [POS_W-1:0]  slim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r  <= SPB_RST;
      subd_r <= SUBD_RST;
      glen_r <= GLEN_RST;
      str_r  <= STR_RST;
      slim_r <= SLIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPB:  spb_r  <= cfg_data[SPB_W-1:0];
        CFG_SUBD: subd_r <= cfg_data[SUBD_W-1:0];
        CFG_GLEN: glen_r <= cfg_data[POS_W-1:0];
        CFG_STR:  str_r  <= cfg_data[STR_W-1:0];
        CFG_SLIM: slim_r <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [FUNC_W-1:0]  func_r;
  logic [POS_W-1:0]   s_r;
  logic [POS_W-1:0]   tol_r;
  logic [SUBD_W-1:0]  d_r;

  // restoring divider: step = beat spacing / d
  logic [SPB_W-1:0]   quo_r;
  logic [SUBD_W-1:0]  rem_r;
  logic [DIVC_W-1:0]  divc_r;
  logic [SUBD_W:0]    rem_sh;
  logic               rem_ge;
  logic [SPB_W-1:0]   step;

  assign rem_sh = {rem_r, quo_r[SPB_W-1]};
  assign rem_ge = rem_sh >= {1'b0, d_r};
  assign step   = (quo_r == '0) ? SPB_W'(1) : quo_r;

  // grid walker
  logic [BCNT_W-1:0]  bcnt_r;
  logic [SUBD_W-1:0]  k_r;
  logic [BP_W-1:0]    beat_pos_r;
  logic [PP_W-1:0]    pt_pos_r;
  logic [LST_W-1:0]   listed_r;
  logic [PP_W-1:0]    best_r;
  logic [POS_W-1:0]   near_sep_r;
  logic               hit_r;
  logic [BCNT_W-1:0]  hit_idx_r;

  logic               in_grid, list_ok, last_k;
  logic [PP_W-1:0]    s_ext, pt_dist;
  logic [BP_W-1:0]    s_bext, beat_dist;
  logic               hit_now;
  logic [BP_W-1:0]    beat_pos_inc;

  assign in_grid  = (bcnt_r < BCNT_W'(MAX_BEAT_COUNT)) && (beat_pos_r < BP_W'(glen_r));
  assign list_ok  = (listed_r + LST_W'(d_r)) < LST_W'(TOTAL);
  assign last_k   = (k_r == d_r - SUBD_W'(1));
  assign s_ext    = PP_W'(s_r);
  assign s_bext   = BP_W'(s_r);
  assign pt_dist  = (pt_pos_r >= s_ext) ? pt_pos_r - s_ext : s_ext - pt_pos_r;
  assign beat_dist = (beat_pos_r >= s_bext) ? beat_pos_r - s_bext : s_bext - beat_pos_r;
  assign beat_pos_inc = beat_pos_r + BP_W'(spb_r);

  always_comb begin
    hit_now = 1'b0;
    unique case (func_t'(func_r))
      FN_ONBEAT: hit_now = in_grid && (beat_dist <= BP_W'(tol_r));
      FN_LOOKUP: hit_now = in_grid && (beat_pos_r == s_bext);
      default:   hit_now = 1'b0;
    endcase
  end

  always_comb begin
    sts.div_done = (divc_r == DIVC_W'(SPB_W));
    unique case (func_t'(func_r))
      FN_QUANT:  sts.scan_done = (k_r == '0) && !(in_grid && list_ok);
      FN_ONBEAT,
      FN_LOOKUP: sts.scan_done = !in_grid || hit_now;
      default:   sts.scan_done = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r      <= in_func;
      s_r         <= in_sample_pos;
      tol_r       <= in_tolerance;
      d_r         <= (subd_r == '0) ? SUBD_W'(1) : subd_r;
      quo_r       <= spb_r;
      rem_r       <= '0;
      divc_r      <= '0;
      bcnt_r      <= '0;
      k_r         <= '0;
      beat_pos_r  <= '0;
      pt_pos_r    <= '0;
      listed_r    <= '0;
      best_r      <= PP_W'(in_sample_pos);
      near_sep_r  <= slim_r;
      hit_r       <= 1'b0;
      hit_idx_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= rem_ge ? SUBD_W'(rem_sh - {1'b0, d_r}) : rem_sh[SUBD_W-1:0];
      quo_r  <= {quo_r[SPB_W-2:0], rem_ge};
      divc_r <= divc_r + DIVC_W'(1);
    end
    if (cmd.scan_step && !sts.scan_done) begin
      if (func_r == FN_QUANT) begin
        // keep the earlier point on equal distance
        if (pt_dist < PP_W'(near_sep_r)) begin
          near_sep_r <= pt_dist[POS_W-1:0];
          best_r     <= pt_pos_r;
        end
        if (last_k) begin
          k_r        <= '0;
          bcnt_r     <= bcnt_r + BCNT_W'(1);
          beat_pos_r <= beat_pos_inc;
          pt_pos_r   <= PP_W'(beat_pos_inc);
          listed_r   <= listed_r + LST_W'(d_r);
        end else begin
          k_r      <= k_r + SUBD_W'(1);
          pt_pos_r <= pt_pos_r + PP_W'(step);
        end
      end else begin
        bcnt_r     <= bcnt_r + BCNT_W'(1);
        beat_pos_r <= beat_pos_inc;
      end
    end
    if (cmd.scan_step && sts.scan_done) begin
      hit_r     <= hit_now;
      hit_idx_r <= bcnt_r;
    end
  end

  // snap: move toward the best point by strength/256
  logic [STR_W-1:0]   str_sat;
  logic               ge;
  logic [POS_W-1:0]   mag;
  logic [PROD_W-1:0]  prod_r;
  logic               ge_r;

  assign str_sat = (str_r > STR_FULL) ? STR_FULL : str_r;
  assign ge      = best_r >= s_ext;
  assign mag     = ge ? POS_W'(best_r - s_ext) : POS_W'(s_ext - best_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'(mag) * PROD_W'(str_sat);
      ge_r   <= ge;
    end
  end

  logic [POS_W:0]     up_sum;
  logic [PROD_W:0]    dn_round;
  logic [POS_W-1:0]   qpos;
  logic [31:0]        idx_full;

  assign up_sum   = {1'b0, s_r} + (POS_W+1)'(prod_r[PROD_W-1:8]);
  assign dn_round = (PROD_W+1)'(prod_r) + (PROD_W+1)'(255);
  assign idx_full = 32'(hit_idx_r);

  always_comb begin
    if (ge_r) begin
      qpos = up_sum[POS_W] ? POS_MAX : up_sum[POS_W-1:0];
    end else begin
      qpos = s_r - dn_round[POS_W+7:8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (func_t'(func_r))
        FN_QUANT: begin
          out_quantized_pos <= qpos;
          out_on_beat       <= 1'b0;
          out_beat_found    <= 1'b0;
          out_beat_index    <= '0;
        end
        FN_ONBEAT: begin
          out_quantized_pos <= '0;
          out_on_beat       <= hit_r;
          out_beat_found    <= 1'b0;
          out_beat_index    <= '0;
        end
        FN_LOOKUP: begin
          out_quantized_pos <= '0;
          out_on_beat       <= 1'b0;
          out_beat_found    <= hit_r;
          out_beat_index    <= hit_r ? idx_full[IDX_W-1:0] : '0;
        end
        default: begin
          out_quantized_pos <= '0;
          out_on_beat       <= 1'b0;
          out_beat_found    <= 1'b0;
          out_beat_index    <= '0;
        end
      endcase
    end
  end

endmodule

/* hdl/beat_grid_quantizer_top.sv */
// Beat grid quantizer: one result item per input item; grid walked again per item.
// Steps per item: step divider, walk over the points or beats, snap multiply and
// result load, then out_valid. The input stalls while an item is in work and while
// a finished item waits for the output slot, so a new item is taken only once the
// last one is done.
// rst_n is synchronous, active low: loads register defaults, empties output.
module beat_grid_quantizer_top
  import bgq_pkg::*;
#(
  parameter int MAX_BEAT_COUNT   = BGQ_MAX_BEAT_COUNT,
  parameter int MAX_SUBDIVISIONS = BGQ_MAX_SUBDIV
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [POS_W-1:0]   in_sample_pos,
  input  logic [POS_W-1:0]   in_tolerance,
  // result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [POS_W-1:0]   out_quantized_pos,
  output logic               out_on_beat,
  output logic               out_beat_found,
  output logic [IDX_W-1:0]   out_beat_index,
  // register writes, always taken
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t sts;

  // writes are accepted at once; to be done only while the block is idle (not enforced here)
  assign cfg_ready = 1'b1;

  // controller: idle, divide, walk, multiply, deliver
  bgq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: registers, divider, walker, snap math, output register
  bgq_datapath #(
    .MAX_BEAT_COUNT   (MAX_BEAT_COUNT),
    .MAX_SUBDIVISIONS (MAX_SUBDIVISIONS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_func           (in_func),
    .in_sample_pos     (in_sample_pos),
    .in_tolerance      (in_tolerance),
    .out_quantized_pos (out_quantized_pos),
    .out_on_beat       (out_on_beat),
    .out_beat_found    (out_beat_found),
    .out_beat_index    (out_beat_index)
  );

endmodule

/* test/grid_answer_checker.sv */
// Checker for the beat grid quantizer: tracks register writes, predicts each answer
// and compares it with the block's result items. Depends on bgq_pkg only.
module grid_answer_checker
  import bgq_pkg::*;
#(
  parameter int MAX_BEAT_COUNT   = BGQ_MAX_BEAT_COUNT,
  parameter int MAX_SUBDIVISIONS = BGQ_MAX_SUBDIV
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [POS_W-1:0]   in_sample_pos,
  input  logic [POS_W-1:0]   in_tolerance,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [POS_W-1:0]   out_quantized_pos,
  input  logic               out_on_beat,
  input  logic               out_beat_found,
  input  logic [IDX_W-1:0]   out_beat_index,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [CFG_D_W-1:0] cfg_data,
  output int                 fault_count,
  output int                 answers_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0] quantized_pos;
    logic             on_beat;
    logic             beat_found;
    logic [IDX_W-1:0] beat_index;
  } grid_answer_t;

  logic [SPB_W-1:0]  beat_spacing;
  logic [SUBD_W-1:0] points_per_beat;
  logic [POS_W-1:0]  grid_end;
  logic [STR_W-1:0]  snap_strength;
  logic [POS_W-1:0]  snap_reach;

  grid_answer_t due_answers[$];
  int           faults;

  // Beats lie at k*spacing below grid_end, capped at the beat limit.
  function automatic longint unsigned count_beats();
    longint unsigned n, pos;
    n   = 0;
    pos = 0;
    while (pos < grid_end && n < MAX_BEAT_COUNT) begin
      n++;
      pos += beat_spacing;
    end
    return n;
  endfunction

  function automatic grid_answer_t predict_answer(input func_t f,
                                                  input logic [POS_W-1:0] pos,
                                                  input logic [POS_W-1:0] tol);
    grid_answer_t    a;
    longint unsigned s, per_beat, step, beats, listed, best, near_sep;
    longint unsigned b, k, pt, sep, pull, moved;
    longint          list_cap;
    a     = '0;
    s     = pos;
    beats = count_beats();
    case (f)
      FN_QUANT: begin
        per_beat = (points_per_beat == 0) ? 1 : points_per_beat;
        step     = beat_spacing / per_beat;
        if (step == 0) step = 1;
        list_cap  = longint'(MAX_BEAT_COUNT) * longint'(MAX_SUBDIVISIONS) - longint'(per_beat);
        listed    = 0;
        best      = s;
        near_sep  = snap_reach;
        // Strictly closer wins, so a tie keeps the earlier point.
        for (b = 0; b < beats && $signed(listed) < list_cap; b++) begin
          for (k = 0; k < per_beat; k++) begin
            pt  = b * beat_spacing + k * step;
            sep = (pt >= s) ? pt - s : s - pt;
            if (sep < near_sep) begin
              near_sep = sep;
              best     = pt;
            end
            listed++;
          end
        end
        pull = (snap_strength > STR_FULL) ? STR_FULL : snap_strength;
        if (best >= s) moved = s + (((best - s) * pull) >> 8);
        else moved = s - ((((s - best) * pull) + 255) >> 8);
        if (moved > POS_MAX) moved = POS_MAX;
        a.quantized_pos = moved[POS_W-1:0];
      end
      FN_ONBEAT: begin
        for (b = 0; b < beats && !a.on_beat; b++) begin
          pt  = b * beat_spacing;
          sep = (pt >= s) ? pt - s : s - pt;
          if (sep <= tol) a.on_beat = 1'b1;
        end
      end
      FN_LOOKUP: begin
        for (b = 0; b < beats && !a.beat_found; b++) begin
          if (b * beat_spacing == s) begin
            a.beat_found = 1'b1;
            a.beat_index = b[IDX_W-1:0];
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk) begin : watch
    grid_answer_t seen, want;
    if (!rst_n) begin
      beat_spacing    = SPB_RST;
      points_per_beat = SUBD_RST;
      grid_end        = GLEN_RST;
      snap_strength   = STR_RST;
      snap_reach      = SLIM_RST;
      due_answers.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {out_quantized_pos, out_on_beat, out_beat_found, out_beat_index};
        if (due_answers.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("%t: result item with none awaited: q=%0d on=%0b found=%0b idx=%0d",
                     $realtime, seen.quantized_pos, seen.on_beat, seen.beat_found,
                     seen.beat_index);
        end else begin
          want = due_answers.pop_front();
          if (seen.quantized_pos !== want.quantized_pos || seen.on_beat !== want.on_beat ||
              seen.beat_found !== want.beat_found || seen.beat_index !== want.beat_index) begin
            faults++;
            if (faults <= 10)
              $display("%t: want q=%0d on=%0b f=%0b i=%0d, got q=%0d on=%0b f=%0b i=%0d",
                       $realtime, want.quantized_pos, want.on_beat, want.beat_found,
                       want.beat_index, seen.quantized_pos, seen.on_beat, seen.beat_found,
                       seen.beat_index);
          end
        end
      end
      if (in_valid && !in_stall)
        due_answers.push_back(predict_answer(func_t'(in_func), in_sample_pos, in_tolerance));
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SPB:  beat_spacing    = cfg_data[SPB_W-1:0];
          CFG_SUBD: points_per_beat = cfg_data[SUBD_W-1:0];
          CFG_GLEN: grid_end        = cfg_data[POS_W-1:0];
          CFG_STR:  snap_strength   = cfg_data[STR_W-1:0];
          CFG_SLIM: snap_reach      = cfg_data[POS_W-1:0];
          default: ;
        endcase
      end
    end
    fault_count <= faults;
    answers_due <= due_answers.size();
  end

endmodule

/* test/beat_grid_quantizer_top_tb.sv */
// Testbench top for beat_grid_quantizer_top: drives register writes and input items,
// idles both channels at random and gives the verdict. Depends on bgq_pkg, the RTL
// and grid_answer_checker.
module beat_grid_quantizer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bgq_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 12;
  localparam int WATCHDOG_LIMIT  = 40000;  // worst item walks ~8k points, plus stalls
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 40;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_ITEMS     = 12;
  localparam int HEAVY_ITEMS     = 4;
  localparam int HEAVY_PHASE     = 5;
  localparam int HOLD_PHASE      = 2;
  // No register sits at this index; a write to it must change nothing.
  localparam logic [CFG_A_W-1:0] SPARE_REG_IDX = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [FUNC_W-1:0]  in_func;
  logic [POS_W-1:0]   in_sample_pos;
  logic [POS_W-1:0]   in_tolerance;
  logic               out_valid;
  logic               out_stall;
  logic [POS_W-1:0]   out_quantized_pos;
  logic               out_on_beat;
  logic               out_beat_found;
  logic [IDX_W-1:0]   out_beat_index;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_A_W-1:0] cfg_index;
  logic [CFG_D_W-1:0] cfg_data;

  int   fault_count;
  int   answers_due;
  int   idle_cycles;
  logic accepted;
  bit   hold_request;  // ask the result side for one long hold-off
  bit   steady;        // no gaps and no stalls while set

  beat_grid_quantizer_top u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_sample_pos     (in_sample_pos),
    .in_tolerance      (in_tolerance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_quantized_pos (out_quantized_pos),
    .out_on_beat       (out_on_beat),
    .out_beat_found    (out_beat_found),
    .out_beat_index    (out_beat_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  grid_answer_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_sample_pos     (in_sample_pos),
    .in_tolerance      (in_tolerance),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_quantized_pos (out_quantized_pos),
    .out_on_beat       (out_on_beat),
    .out_beat_found    (out_beat_found),
    .out_beat_index    (out_beat_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fault_count       (fault_count),
    .answers_due       (answers_due)
  );

  always #HALF_PERIOD clk = ~clk;

  // Idle length: mostly none, often a few cycles, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 60);
  endfunction

  // Drive one register write and hold it until taken; leave valid high so that
  // back-to-back writes need no second assignment in the same step.
  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all five registers, then drop the write valid.
  task automatic program_grid(input longint unsigned spb, input longint unsigned subd,
                              input longint unsigned glen, input longint unsigned str,
                              input longint unsigned slim);
    write_reg(CFG_SPB, CFG_D_W'(spb));
    write_reg(CFG_SUBD, CFG_D_W'(subd));
    write_reg(CFG_GLEN, CFG_D_W'(glen));
    write_reg(CFG_STR, CFG_D_W'(str));
    write_reg(CFG_SLIM, CFG_D_W'(slim));
    cfg_valid <= 1'b0;
  endtask

  // Offer one item after an optional gap and hold it until accepted.
  task automatic offer_item(input func_t f, input logic [POS_W-1:0] pos,
                            input logic [POS_W-1:0] tol);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_sample_pos <= pos;
    in_tolerance  <= tol;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every awaited result has come back. The first
  // edge lets the checker count an item accepted on the edge just passed.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // One random setting followed by items: most sit on or near beats, the rest are
  // noise over the whole range. A heavy phase fills the grid to its point limit.
  task automatic run_random_phase(input bit heavy, input int count);
    longint unsigned spb, subd, glen, str, slim, beats_hint, pos, off, tol;
    func_t           f;
    int              r, n;
    if (heavy) begin
      spb  = $urandom_range(1, 3);
      subd = BGQ_MAX_SUBDIV;
      glen = $urandom_range(8192, POS_MAX);
    end else begin
      spb  = $urandom_range(0, 1) ? $urandom_range(1, 4000) : $urandom_range(1, (1 << SPB_W) - 1);
      subd = $urandom_range(0, (1 << SUBD_W) - 1);
      glen = $urandom_range(0, 40) * spb + $urandom_range(0, spb - 1);
      if (glen > POS_MAX) glen = POS_MAX;
    end
    str = ($urandom_range(0, 3) == 0) ? STR_FULL : $urandom_range(0, (1 << STR_W) - 1);
    case ($urandom_range(0, 2))
      0:       slim = $urandom_range(0, POS_MAX);
      1:       slim = $urandom_range(0, spb);
      default: slim = POS_MAX;
    endcase
    program_grid(spb, subd, glen, str, slim);
    beats_hint = glen / spb + 1;
    if (beats_hint > BGQ_MAX_BEAT_COUNT) beats_hint = BGQ_MAX_BEAT_COUNT;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, 9);
      f = (r < 4) ? FN_QUANT : (r < 7) ? FN_ONBEAT : (r < 9) ? FN_LOOKUP
                                                             : func_t'($urandom_range(0, 3));
      r = $urandom_range(0, 9);
      if (r < 3) begin
        pos = $urandom_range(0, POS_MAX);
      end else begin
        pos = $urandom_range(0, beats_hint) * spb;
        off = (r < 6) ? 0 : (r < 8) ? $urandom_range(0, 8) : $urandom_range(0, spb);
        if ($urandom_range(0, 1) && pos >= off) pos -= off;
        else pos += off;
        if (pos > POS_MAX) pos = POS_MAX;
      end
      case ($urandom_range(0, 3))
        0:       tol = $urandom_range(0, POS_MAX);
        1:       tol = $urandom_range(0, 16);
        default: tol = $urandom_range(0, spb);
      endcase
      offer_item(f, pos[POS_W-1:0], tol[POS_W-1:0]);
    end
    drain();
  endtask

  // Result side: random stall runs, none while steady, and one long hold-off on
  // request so that the block fills up and holds its input.
  initial begin : result_sink
    int   run_left;
    logic level;
    run_left  = 0;
    level     = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        run_left = 0;
      end
      if (run_left == 0) begin
        level    = !steady && ($urandom_range(0, 2) == 0);
        run_left = level ? 1 + pick_gap() : $urandom_range(1, 16);
      end
      out_stall <= level;
      run_left--;
    end
  end

  // Count cycles in which no channel moves anything; give up past the limit.
  assign accepted = (in_valid && !in_stall) || (out_valid && !out_stall) ||
                    (cfg_valid && cfg_ready);

  always @(posedge clk) begin
    if (!rst_n || accepted) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    int phase;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_func       = FN_QUANT;
    in_sample_pos = '0;
    in_tolerance  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    hold_request  = 1'b0;
    steady        = 1'b0;
    idle_cycles   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings leave the grid empty: quantize returns the sample, the
    // tests find no beat, and the unused func code gives an all-zero item.
    offer_item(FN_QUANT, 24'd1234, '0);
    offer_item(FN_QUANT, POS_MAX, POS_MAX);
    offer_item(FN_ONBEAT, '0, POS_MAX);
    offer_item(FN_LOOKUP, '0, '0);
    offer_item(FN_NONE, POS_MAX, POS_MAX);
    drain();

    // Ten beats 1000 apart, four points each, full snap with unlimited reach.
    write_reg(SPARE_REG_IDX, '1);
    program_grid(1000, 4, 10000, STR_FULL, POS_MAX);
    offer_item(FN_QUANT, 24'd125, '0);      // tie between 0 and 250 keeps 0
    offer_item(FN_QUANT, 24'd1249, '0);
    offer_item(FN_QUANT, POS_MAX, '0);      // far past the grid, snaps to its last point
    offer_item(FN_ONBEAT, 24'd2010, 24'd10);
    offer_item(FN_ONBEAT, 24'd2010, 24'd9);
    offer_item(FN_LOOKUP, 24'd3000, '0);
    offer_item(FN_LOOKUP, 24'd3001, '0);
    offer_item(FN_LOOKUP, 24'd10000, '0);   // grid end itself is not a beat
    drain();

    // Seven points per beat, half strength, short reach.
    program_grid(100, 7, 350, 128, 60);
    offer_item(FN_QUANT, 24'd123, '0);
    offer_item(FN_QUANT, 24'd399, '0);
    offer_item(FN_QUANT, 24'd7, '0);
    drain();

    // Zero spacing stacks every beat at 0; zero subdivision counts as one and
    // strength above full saturates.
    program_grid(0, 0, 1, (1 << STR_W) - 1, 5);
    offer_item(FN_QUANT, 24'd3, '0);
    offer_item(FN_LOOKUP, '0, '0);
    offer_item(FN_ONBEAT, 24'd7, 24'd6);
    drain();

    // Last point lies past the top of the range and is nearest to the top
    // sample, so the snapped position saturates.
    program_grid(1016802, 2, POS_MAX, STR_FULL, POS_MAX);
    offer_item(FN_QUANT, POS_MAX, '0);
    offer_item(FN_LOOKUP, 24'd16268832, '0);
    offer_item(FN_ONBEAT, POS_MAX, '0);
    drain();

    // Widest spacing, five points, no strength and no reach.
    program_grid((1 << SPB_W) - 1, 5, POS_MAX, 0, 0);
    offer_item(FN_QUANT, 24'd500000, '0);
    drain();

    // Random settings; some phases run without idling, one with a long hold-off.
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady = (phase % 3 == 1);
      if (phase == HOLD_PHASE) hold_request = 1'b1;
      run_random_phase(1'b0, PHASE_ITEMS);
      if (phase == HEAVY_PHASE) run_random_phase(1'b1, HEAVY_ITEMS);
    end
    steady = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0 && answers_due == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/bgq_pkg.sv
hdl/bgq_ctrl.sv
hdl/bgq_datapath.sv
hdl/beat_grid_quantizer_top.sv
test/grid_answer_checker.sv
test/beat_grid_quantizer_top_tb.sv
